// ----- rtl/stsi_pkg.sv -----
// Shared types and constants for the sorted table insert/search block.
// Used by the cell, the cell row, the top level and the port checker.
package stsi_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DATA_W     = 32;
  localparam int POS_W      = 6;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } kind_t;

  typedef struct packed {
    logic g;
    logic eq;
  } cell_flags_t;

endpackage

// ----- rtl/stsi_cell.sv -----
// One table cell: holds one entry, compares it with the request value and
// takes its lower neighbor's entry or the request value on an insert.
// Depends on stsi_pkg.
module stsi_cell import stsi_pkg::*; (
  input  logic                     clk,
  input  logic                     cell_valid,
  input  logic signed [DATA_W-1:0] req_value,
  input  logic signed [DATA_W-1:0] prev_entry,
  input  logic                     prev_g,
  input  logic                     shift_en,
  output logic signed [DATA_W-1:0] entry,
  output cell_flags_t              flags
);

  logic signed [DATA_W-1:0] entry_r;

  assign entry    = entry_r;
  assign flags.g  = !cell_valid || (req_value < entry_r);
  assign flags.eq = cell_valid && (req_value == entry_r);

  always_ff @(posedge clk) begin
    if (shift_en && flags.g) begin
      entry_r <= prev_g ? prev_entry : req_value;
    end
  end

endmodule

// ----- rtl/stsi_row.sv -----
// Row of table cells chained from index 0 upward; each cell hands its entry
// and compare flag to the next one. Depends on stsi_pkg and stsi_cell.
module stsi_row import stsi_pkg::*; (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] req_value,
  input  logic                     shift_en,
  input  logic [CNT_W-1:0]         fill,
  output logic [CAPACITY-1:0]      g_vec,
  output logic [CAPACITY-1:0]      eq_vec
);

  logic signed [DATA_W-1:0] entry_w [CAPACITY];
  cell_flags_t              flags_w [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_g;
    logic signed [DATA_W-1:0] prev_entry;

    if (i == 0) begin : g_first
      assign prev_g     = 1'b0;
      assign prev_entry = req_value;
    end else begin : g_rest
      assign prev_g     = flags_w[i-1].g;
      assign prev_entry = entry_w[i-1];
    end

    stsi_cell u_cell (
      .clk        (clk),
      .cell_valid (CNT_W'(i) < fill),
      .req_value  (req_value),
      .prev_entry (prev_entry),
      .prev_g     (prev_g),
      .shift_en   (shift_en),
      .entry      (entry_w[i]),
      .flags      (flags_w[i])
    );

    assign g_vec[i]  = flags_w[i].g;
    assign eq_vec[i] = flags_w[i].eq;
  end

endmodule

// ----- rtl/sorted_table_insert_search.sv -----
// Sorted table insert/search block: a chain of compare-and-shift cells holding
// an ascending table of signed 32-bit values, plus the request sequencer.
//
// Input channel in_*: in_tuser = kind (0 lookup, 1 insert), in_tdata = value.
// Result channel out_*: out_tuser = status (0 ok, 1 not found, 2 full),
// out_tdata = position (low 6 bits), one result per request.
// Every cell compares its entry with the request value in parallel, in S_EVAL.
// An insert shifts the upper entries up in that same cycle; its result is then
// formed in S_FIN and registered into the output register once that register
// is free. The next request is taken only once the block is back in S_IDLE.
// A lookup walks the binary search over the registered compare flags, one
// halving step per cycle; its result too waits for a free output register.
// Reset empties the table (fill count zero); entries themselves are not
// cleared. A request is accepted while an earlier result still waits in the
// output register; a finished result holds until that register is free.
// Depends on stsi_pkg and stsi_row.
module sorted_table_insert_search import stsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [31:0] value
  input  logic                  in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] position, [7:6] zero
  output logic [1:0]            out_tuser   // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SRCH = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  kind_t                    req_kind_r;
  logic signed [DATA_W-1:0] req_value_r;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic                     full_r, full_nxt;
  logic [CAPACITY-1:0]      g_r, eq_r;
  logic [CAPACITY-1:0]      g_vec, eq_vec;
  logic [CNT_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic                     shift_en, out_free, in_acc;
  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         mid;
  logic [CNT_W-1:0]         slot;

  function automatic logic [CNT_W-1:0] first_set(input logic [CAPACITY-1:0] v);
    logic [CNT_W-1:0] idx;
    idx = CNT_W'(CAPACITY);
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = CNT_W'(k);
      end
    end
    return idx;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign shift_en  = (state_r == S_EVAL) && (req_kind_r == KIND_INSERT) &&
                     (fill_r != CNT_W'(CAPACITY));
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - 1'b1;
  assign mid       = mid_sum[CNT_W:1];
  assign slot      = first_set(g_r);

  stsi_row u_row (
    .clk       (clk),
    .req_value (req_value_r),
    .shift_en  (shift_en),
    .fill      (fill_r),
    .g_vec     (g_vec),
    .eq_vec    (eq_vec)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    full_nxt       = full_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        full_nxt = (fill_r == CNT_W'(CAPACITY));
        lo_nxt   = '0;
        hi_nxt   = fill_r;
        if (req_kind_r == KIND_INSERT) begin
          state_nxt = S_FIN;
          if (shift_en) begin
            fill_nxt = fill_r + 1'b1;
          end
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r >= hi_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISSING;
            out_pos_nxt    = '0;
            state_nxt      = S_IDLE;
          end
        end else if (eq_r[mid[IDX_W-1:0]]) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_pos_nxt    = POS_W'(mid);
            state_nxt      = S_IDLE;
          end
        end else if (g_r[mid[IDX_W-1:0]]) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = full_r ? ST_FULL : ST_OK;
          out_pos_nxt    = full_r ? '0 : POS_W'(slot);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_kind_r  <= kind_t'(in_tuser);
      req_value_r <= in_tdata;
    end
    if (state_r == S_EVAL) begin
      g_r  <= g_vec;
      eq_r <= eq_vec;
    end
    full_r       <= full_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_DATA_W - POS_W)'(0), out_pos_r};

endmodule

// ----- rtl/stsi_port_check.sv -----
// Port-level checker for the sorted table insert/search block, bound to the
// top level. Depends on stsi_pkg and sorted_table_insert_search.
module stsi_port_check import stsi_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_MISSING) ||
                   (out_tuser == ST_FULL))
    else $error("undefined status");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("nonzero position on failed request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("request taken while another is in work");

endmodule

bind sorted_table_insert_search stsi_port_check u_port_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- verif/sorted_table_insert_search_tb.sv -----
// Testbench for sorted_table_insert_search: drives insert and lookup requests
// and checks every result against a behavioral copy of the sorted table.
// Depends on stsi_pkg and the sorted_table_insert_search RTL.
`timescale 1ns / 100ps

module sorted_table_insert_search_tb;
  import stsi_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_GAP     = 12;
  localparam int SETTLE      = 16;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  logic signed [DATA_W-1:0] sorted_vals [CAPACITY];
  int unsigned              fill_cnt = 0;
  answer_t                  pending_answers [$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  hold_off_cycles = 0;
  bit  no_idle = 1'b0;

  sorted_table_insert_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
  endtask

  function automatic answer_t predict_insert(logic signed [DATA_W-1:0] v);
    answer_t     a;
    int unsigned slot;
    a.status   = ST_FULL;
    a.position = '0;
    if (fill_cnt >= CAPACITY) return a;
    slot = fill_cnt;
    for (int unsigned i = 0; i < fill_cnt; i++) begin
      if (v < sorted_vals[i]) begin
        slot = i;
        break;
      end
    end
    for (int unsigned i = fill_cnt; i > slot; i--) sorted_vals[i] = sorted_vals[i-1];
    sorted_vals[slot] = v;
    fill_cnt++;
    a.status   = ST_OK;
    a.position = slot[POS_W-1:0];
    return a;
  endfunction

  function automatic answer_t predict_lookup(logic signed [DATA_W-1:0] v);
    answer_t a;
    int      lo;
    int      hi;
    int      mid;
    lo = 0;
    hi = int'(fill_cnt) - 1;
    a.status   = ST_MISSING;
    a.position = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (sorted_vals[mid] == v) begin
        a.status   = ST_OK;
        a.position = mid[POS_W-1:0];
        return a;
      end
      if (v > sorted_vals[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return a;
  endfunction

  // Favor stored values and their neighbors so lookups hit and duplicates form.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] base;
    int unsigned              sel;
    sel  = $urandom_range(0, 9);
    base = $urandom;
    if (fill_cnt > 0) base = sorted_vals[$urandom_range(0, fill_cnt - 1)];
    case (sel)
      0, 1, 2, 3: return base;
      4: return $urandom_range(0, 1) ? base + 1 : base - 1;
      5: return int'($urandom_range(0, 8)) - 4;
      6: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh7FFF_FFFE;
          default: return 32'sh8000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Enter and leave at a falling edge; record the expected answer on acceptance.
  task automatic send_request(kind_t kind, logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    in_tuser  = kind;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_INSERT) pending_answers.push_back(predict_insert(v));
    else pending_answers.push_back(predict_lookup(v));
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned insert_pct);
    send_request(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_LOOKUP,
                 pick_value());
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_lookup();
    send_request(KIND_LOOKUP, 32'sd0);
    send_request(KIND_LOOKUP, 32'sh7FFF_FFFF);
    send_request(KIND_LOOKUP, 32'sh8000_0000);
  endtask

  task automatic test_ordered_insert();
    send_request(KIND_INSERT, 32'sd0);
    send_request(KIND_INSERT, 32'sh7FFF_FFFF);
    send_request(KIND_INSERT, 32'sh8000_0000);
    send_request(KIND_INSERT, -32'sd1);
    send_request(KIND_INSERT, 32'sd1);
    send_request(KIND_INSERT, 32'sd0);
    send_request(KIND_INSERT, 32'sd0);
  endtask

  task automatic test_lookup_hits_and_misses();
    send_request(KIND_LOOKUP, 32'sh7FFF_FFFF);
    send_request(KIND_LOOKUP, 32'sh8000_0000);
    send_request(KIND_LOOKUP, 32'sd0);
    send_request(KIND_LOOKUP, -32'sd1);
    send_request(KIND_LOOKUP, 32'sd1);
    send_request(KIND_LOOKUP, 32'sd5);
    send_request(KIND_LOOKUP, 32'sh7FFF_FFFE);
    send_request(KIND_LOOKUP, 32'sh8000_0001);
  endtask

  task automatic test_random_growth(int n);
    repeat (n) send_random(15);
  endtask

  task automatic test_table_full();
    while (fill_cnt < CAPACITY) send_request(KIND_INSERT, pick_value());
    send_request(KIND_INSERT, 32'sh7FFF_FFFF);
    send_request(KIND_INSERT, 32'sh8000_0000);
    send_request(KIND_INSERT, sorted_vals[CAPACITY/2]);
    send_request(KIND_LOOKUP, sorted_vals[0]);
    send_request(KIND_LOOKUP, sorted_vals[CAPACITY-1]);
  endtask

  task automatic test_back_to_back(int n);
    no_idle = 1'b1;
    repeat (n) send_random(10);
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure(int n);
    wait_drain();
    hold_off_cycles = 300;
    no_idle = 1'b1;
    repeat (n) send_random(10);
    no_idle = 1'b0;
  endtask

  task automatic test_random_full(int n);
    repeat (n) send_random(10);
  endtask

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int unsigned gap;
      answer_t     want;
      if (hold_off_cycles > 0) begin
        out_tready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d tdata 0x%0h",
                                  out_tuser, out_tdata));
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
        if (out_tdata !== {{(OUT_DATA_W-POS_W){1'b0}}, want.position})
          report_mismatch($sformatf("position tdata 0x%0h, want %0d",
                                    out_tdata, want.position));
      end
      @(negedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_lookup();
    test_ordered_insert();
    test_lookup_hits_and_misses();
    test_random_growth(520);
    test_table_full();
    test_back_to_back(100);
    test_backpressure(40);
    test_random_full(450);

    wait_drain();
    repeat (SETTLE) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
